FILE: src/dft_pkg.sv
// Shared types and constants for the fact table.
package dft_pkg;

  localparam int ROOT_W = 64;
  localparam int ID_W   = 32;
  localparam int KIND_W = 3;
  localparam int TIME_W = 64;
  localparam int CONF_W = 18;
  localparam int VAL_W  = 41;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 8;
  localparam int REV_W  = 32;

  localparam logic [STAT_W-1:0] ST_STORED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUP     = 3'd1;
  localparam logic [STAT_W-1:0] ST_RETIRED = 3'd2;
  localparam logic [STAT_W-1:0] ST_INVALID = 3'd3;
  localparam logic [STAT_W-1:0] ST_FUTURE  = 3'd4;

  localparam logic [CONF_W-2:0] CONF_ONE_Q16   = 17'd65536;
  localparam logic [VAL_W-2:0]  CLOTH_LIMIT_Q8 = 40'd512;
  localparam logic [VAL_W-2:0]  OTHER_LIMIT_Q8 = 40'd256000000000;

  localparam logic [KIND_W-1:0] CLOTHING_RESET = 3'd1;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic [ID_W-1:0]   subject;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   object;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t key;
  } slot_t;

endpackage

FILE: src/dft_ifs.sv
// Handshake channels: fact input, result output and register write.
interface dft_fact_if;
  logic                                valid;
  logic                                ready;
  logic [dft_pkg::ROOT_W-1:0]          fact_root;
  logic [dft_pkg::ID_W-1:0]            subject_id;
  logic [dft_pkg::KIND_W-1:0]          kind_code;
  logic [dft_pkg::ID_W-1:0]            object_id;
  logic signed [dft_pkg::TIME_W-1:0]   fact_time;
  logic signed [dft_pkg::TIME_W-1:0]   now_time;
  logic signed [dft_pkg::CONF_W-1:0]   confidence_q16;
  logic signed [dft_pkg::VAL_W-1:0]    value_q8;
  modport source (output valid, fact_root, subject_id, kind_code, object_id, fact_time,
                  now_time, confidence_q16, value_q8, input ready);
  modport sink (input valid, fact_root, subject_id, kind_code, object_id, fact_time,
                now_time, confidence_q16, value_q8, output ready);
endinterface

interface dft_result_if;
  logic                       valid;
  logic                       ready;
  logic [dft_pkg::STAT_W-1:0] status;
  logic                       evicted;
  logic [dft_pkg::ROOT_W-1:0] evicted_root;
  logic [dft_pkg::CNT_W-1:0]  stored_count;
  logic [dft_pkg::REV_W-1:0]  revision_count;
  modport source (output valid, status, evicted, evicted_root, stored_count,
                  revision_count, input ready);
  modport sink (input valid, status, evicted, evicted_root, stored_count,
                revision_count, output ready);
endinterface

interface dft_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [dft_pkg::KIND_W-1:0] clothing_kind_code;
  modport source (output valid, clothing_kind_code, input ready);
  modport sink (input valid, clothing_kind_code, output ready);
endinterface

FILE: src/dedup_fact_table_min_root_evict_core.sv
// An invalid, future or retired fact goes straight from idle to the result word;
// a duplicate gets it after the search pass, a stored fact after search and write.
// Throughput: one fact at a time; the ring of CAPACITY cells rotates once to
// search for a duplicate, the smallest root and a free slot, and once more to store.
// A result word waits in its register until taken, then the next fact is accepted.
// Reset: synchronous; empties the table, clears watermark and counters, kind code to 1.
module dedup_fact_table_min_root_evict_core #(
  parameter int CAPACITY = 128,
  parameter int KIND_MAX = 7,
  parameter int ID_BITS  = 32
) (
  input  logic       clk,
  input  logic       rst,
  dft_fact_if.sink   fact,
  dft_result_if.source result,
  dft_cfg_if.sink    cfg
);

  localparam int POS_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int HELD_W = $clog2(CAPACITY + 1);
  localparam int KEEP_W = (ID_BITS < dft_pkg::ID_W) ? ID_BITS : dft_pkg::ID_W;
  localparam logic [dft_pkg::ID_W-1:0] ID_MASK =
    dft_pkg::ID_W'({KEEP_W{1'b1}});
  localparam logic [POS_W-1:0]  LAST_POS = POS_W'(CAPACITY - 1);
  localparam logic [HELD_W-1:0] FULL     = HELD_W'(CAPACITY);
  localparam logic [dft_pkg::KIND_W-1:0] KIND_LIM = dft_pkg::KIND_W'(KIND_MAX);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0]                   state;
  logic [POS_W-1:0]             pos;
  logic [dft_pkg::KIND_W-1:0]   clothing;
  logic [dft_pkg::ROOT_W-1:0]   watermark;
  logic [dft_pkg::REV_W-1:0]    revision;
  logic [HELD_W-1:0]            held;
  dft_pkg::entry_t              new_key;
  logic                         dup;
  logic                         have_min;
  logic [dft_pkg::ROOT_W-1:0]   min_root;
  logic [POS_W-1:0]             min_pos;
  logic                         have_free;
  logic [POS_W-1:0]             free_pos;
  logic [POS_W-1:0]             target;
  logic [dft_pkg::STAT_W-1:0]   res_status;
  logic                         res_evicted;
  logic [dft_pkg::ROOT_W-1:0]   res_root;

  dft_pkg::slot_t ring [CAPACITY];
  dft_pkg::slot_t head;
  dft_pkg::slot_t head_next;
  logic           shift;

  // Early checks on the incoming word
  logic [dft_pkg::ID_W-1:0] in_subj;
  logic [dft_pkg::ID_W-1:0] in_obj;
  logic [dft_pkg::VAL_W-2:0] limit;
  logic in_valid_fact;
  logic in_future;
  logic in_retired;
  logic accept;

  assign in_subj = fact.subject_id & ID_MASK;
  assign in_obj  = fact.object_id & ID_MASK;
  assign limit   = (fact.kind_code == clothing) ? dft_pkg::CLOTH_LIMIT_Q8
                                                : dft_pkg::OTHER_LIMIT_Q8;
  assign in_valid_fact = (fact.fact_root != '0) && (in_subj != '0)
    && (fact.kind_code <= KIND_LIM) && !fact.fact_time[dft_pkg::TIME_W-1]
    && !fact.confidence_q16[dft_pkg::CONF_W-1]
    && (fact.confidence_q16[dft_pkg::CONF_W-2:0] <= dft_pkg::CONF_ONE_Q16)
    && !fact.value_q8[dft_pkg::VAL_W-1]
    && (fact.value_q8[dft_pkg::VAL_W-2:0] <= limit);
  assign in_future  = fact.now_time < fact.fact_time;
  assign in_retired = fact.fact_root <= watermark;
  assign accept     = fact.valid && fact.ready;

  assign fact.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clothing <= dft_pkg::CLOTHING_RESET;
    end else if (cfg.valid) begin
      clothing <= cfg.clothing_kind_code;
    end
  end

  // Ring of cells; cell 0 is the head that the search looks at
  assign shift = (state == S_SCAN) || (state == S_WRITE);
  assign head  = ring[0];

  always_comb begin
    head_next = head;
    if ((state == S_WRITE) && (pos == target)) begin
      head_next.valid = 1'b1;
      head_next.key   = new_key;
    end
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == CAPACITY - 1) begin : g_last
        dft_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .slot_in(head_next),
                         .slot_out(ring[g]));
      end else begin : g_mid
        dft_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .slot_in(ring[g+1]),
                         .slot_out(ring[g]));
      end
    end
  endgenerate

  logic full;
  assign full = (held == FULL);

  always_ff @(posedge clk) begin
    if (accept) begin
      new_key.root    <= fact.fact_root;
      new_key.subject <= in_subj;
      new_key.kind    <= fact.kind_code;
      new_key.object  <= in_obj;
    end
    if (state == S_SCAN) begin
      if (head.valid && (!have_min || (head.key.root < min_root))) begin
        min_root <= head.key.root;
        min_pos  <= pos;
      end
      if (!head.valid && !have_free) begin
        free_pos <= pos;
      end
      if ((pos == LAST_POS) && !(dup || (head.valid && (head.key == new_key)))) begin
        if (full) begin
          if (head.valid && (!have_min || (head.key.root < min_root))) begin
            target <= pos;
          end else begin
            target <= min_pos;
          end
        end else begin
          if (!have_free && !head.valid) begin
            target <= pos;
          end else begin
            target <= free_pos;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pos         <= '0;
      watermark   <= '0;
      revision    <= '0;
      held        <= '0;
      dup         <= 1'b0;
      have_min    <= 1'b0;
      have_free   <= 1'b0;
      res_status  <= dft_pkg::ST_STORED;
      res_evicted <= 1'b0;
      res_root    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            pos         <= '0;
            dup         <= 1'b0;
            have_min    <= 1'b0;
            have_free   <= 1'b0;
            res_evicted <= 1'b0;
            res_root    <= '0;
            if (!in_valid_fact) begin
              res_status <= dft_pkg::ST_INVALID;
              state      <= S_OUT;
            end else if (in_future) begin
              res_status <= dft_pkg::ST_FUTURE;
              state      <= S_OUT;
            end else if (in_retired) begin
              res_status <= dft_pkg::ST_RETIRED;
              state      <= S_OUT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (head.valid && (head.key == new_key)) begin
            dup <= 1'b1;
          end
          if (head.valid) begin
            have_min <= 1'b1;
          end else begin
            have_free <= 1'b1;
          end
          if (pos == LAST_POS) begin
            pos <= '0;
            if (dup || (head.valid && (head.key == new_key))) begin
              res_status <= dft_pkg::ST_DUP;
              state      <= S_OUT;
            end else begin
              res_status <= dft_pkg::ST_STORED;
              revision   <= revision + dft_pkg::REV_W'(1);
              state      <= S_WRITE;
              if (full) begin
                // evict the smallest root and raise the watermark to it
                res_evicted <= 1'b1;
                if (head.valid && (!have_min || (head.key.root < min_root))) begin
                  res_root <= head.key.root;
                  if (head.key.root > watermark) watermark <= head.key.root;
                end else begin
                  res_root <= min_root;
                  if (min_root > watermark) watermark <= min_root;
                end
              end else begin
                held <= held + HELD_W'(1);
              end
            end
          end else begin
            pos <= pos + POS_W'(1);
          end
        end
        S_WRITE: begin
          if (pos == LAST_POS) begin
            pos   <= '0;
            state <= S_OUT;
          end else begin
            pos <= pos + POS_W'(1);
          end
        end
        S_OUT: begin
          if (result.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid          = (state == S_OUT);
  assign result.status         = res_status;
  assign result.evicted        = res_evicted;
  assign result.evicted_root   = res_root;
  assign result.stored_count   = dft_pkg::CNT_W'(held);
  assign result.revision_count = revision;

endmodule

FILE: src/dft_cell.sv
// One table slot in the rotating ring of entries.
module dft_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  dft_pkg::slot_t  slot_in,
  output dft_pkg::slot_t  slot_out
);

  logic            valid;
  dft_pkg::entry_t key;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= slot_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      key <= slot_in.key;
    end
  end

  assign slot_out.valid = valid;
  assign slot_out.key   = key;

endmodule
